[hdl/n2cd_pkg.sv]
// Package for the nanosecond-to-calendar converter.
// Holds time constants, the sequencer state type, the step-unit result type
// and the year/month length functions. No dependencies.
`timescale 1ns / 1ps

package n2cd_pkg;

    localparam int unsigned RemW = 64;

    localparam logic [RemW-1:0] NS_PER_SEC  = 64'd1000000000;
    localparam logic [RemW-1:0] NS_PER_MIN  = 64'd60000000000;
    localparam logic [RemW-1:0] NS_PER_HOUR = 64'd3600000000000;
    localparam logic [RemW-1:0] NS_PER_DAY  = 64'd86400000000000;

    localparam logic [11:0] BASE_YEAR  = 12'd2000;
    localparam logic [11:0] YEAR_LIMIT = 12'd4000;
    localparam logic [3:0]  LAST_MONTH_IDX = 4'd11;
    localparam logic [3:0]  JUNE_IDX       = 4'd5;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_YEAR,
        S_MONTH,
        S_DAY,
        S_HOUR,
        S_MIN,
        S_SEC,
        S_DONE
    } state_t;

    // Result of the shared subtract/compare unit
    typedef struct packed {
        logic [RemW-1:0] diff;
        logic            ge;
    } step_res_t;

    // Every fourth year from 2000 is leap; 2000 is a multiple of four
    function automatic logic is_leap(input logic [11:0] yr);
        return (yr[1:0] == 2'b00);
    endfunction

    function automatic logic has_year_leap_sec(input logic [11:0] yr);
        return (yr == 12'd2005) || (yr == 12'd2008) ||
               (yr == 12'd2015) || (yr == 12'd2016);
    endfunction

    // Length of a whole year in nanoseconds
    function automatic logic [RemW-1:0] year_ns(input logic [11:0] yr);
        logic [RemW-1:0] len;
        len = is_leap(yr) ? (64'd366 * NS_PER_DAY) : (64'd365 * NS_PER_DAY);
        if (has_year_leap_sec(yr))
        begin
            len = len + NS_PER_SEC;
        end
        return len;
    endfunction

    // Length of month k (0 = January) in nanoseconds, June extra second included
    function automatic logic [RemW-1:0] month_ns(input logic [11:0] yr,
                                                 input logic [3:0]  k);
        logic [RemW-1:0] len;
        unique case (k)
            4'd1:                      len = is_leap(yr) ? 64'd29 * NS_PER_DAY
                                                         : 64'd28 * NS_PER_DAY;
            4'd3, 4'd5, 4'd8, 4'd10:   len = 64'd30 * NS_PER_DAY;
            default:                   len = 64'd31 * NS_PER_DAY;
        endcase
        if (((yr == 12'd2012) || (yr == 12'd2015)) && (k == JUNE_IDX))
        begin
            len = len + NS_PER_SEC;
        end
        return len;
    endfunction

endpackage

[hdl/n2cd_if.sv]
// Valid/ready channel interfaces for the input count and the calendar result.
// Depends on nothing.
`timescale 1ns / 1ps

interface n2cd_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] raw_nanoseconds;

    modport source (output valid, output raw_nanoseconds, input ready);
    modport sink   (input valid, input raw_nanoseconds, output ready);
endinterface

interface n2cd_out_if;
    logic        valid;
    logic        ready;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [29:0] nanosecond;

    modport source (output valid, output year, output month, output day, output hour,
                    output minute, output second, output nanosecond, input ready);
    modport sink   (input valid, input year, input month, input day, input hour,
                    input minute, input second, input nanosecond, output ready);
endinterface

[hdl/n2cd_step_unit.sv]
// Shared 64-bit subtract and compare unit used by every sequencer step.
// Depends on n2cd_pkg.
`timescale 1ns / 1ps

module n2cd_step_unit
(
    input  logic [n2cd_pkg::RemW-1:0] rem,
    input  logic [n2cd_pkg::RemW-1:0] sub,
    output n2cd_pkg::step_res_t       res
);

    logic [n2cd_pkg::RemW:0] wide_diff;

    // Borrow out of the top clear means rem >= sub
    assign wide_diff = {1'b0, rem} - {1'b0, sub};
    assign res.diff  = wide_diff[n2cd_pkg::RemW-1:0];
    assign res.ge    = ~wide_diff[n2cd_pkg::RemW];

endmodule

[hdl/nanoseconds_to_calendar_date.sv]
// Converts a nanosecond count since 2000-01-01 into calendar fields.
// Depends on n2cd_pkg, n2cd_if and n2cd_step_unit.
`timescale 1ns / 1ps

// One word in, one word out. A single 64-bit subtract/compare unit does all the
// work under a small sequencer: whole years are removed one per cycle, then up to
// twelve whole months, then day, hour, minute and second are found by restoring
// division against shifted constants, and the result is handed off to the output
// register once that is free or being drained. The input is ready only while the
// sequencer is idle; the finished result sits in an output register, so the next
// word can be taken while the result still waits.
// Calendar rules: every fourth year is leap with no century exception, whole-year
// leap seconds in 2005, 2008, 2015 and 2016, and an extra June second in 2012 and
// 2015. The last second of a leap-second year without the June second reports
// month 13, day 1, 00:00:00.
module nanoseconds_to_calendar_date
(
    input  logic                clk,
    input  logic                rst_n,
    n2cd_in_if.sink             in_ch,
    n2cd_out_if.source          out_ch
);

    n2cd_pkg::state_t           state_reg, state_next;
    logic [n2cd_pkg::RemW-1:0]  rem_reg, rem_next;
    logic [11:0]                year_reg, year_next;
    logic [3:0]                 month_reg, month_next;
    logic [4:0]                 dd_reg, dd_next;
    logic [4:0]                 hh_reg, hh_next;
    logic [5:0]                 mm_reg, mm_next;
    logic [5:0]                 ss_reg, ss_next;
    logic [3:0]                 cnt_reg, cnt_next;

    logic                       ovalid_reg, ovalid_next;
    logic                       load_out;
    logic [11:0]                oyear_reg;
    logic [3:0]                 omonth_reg;
    logic [4:0]                 oday_reg;
    logic [4:0]                 ohour_reg;
    logic [5:0]                 omin_reg;
    logic [5:0]                 osec_reg;
    logic [29:0]                ons_reg;

    logic [n2cd_pkg::RemW-1:0]  sub;
    n2cd_pkg::step_res_t        step;

    // Subtrahend for the current step
    always_comb
    begin
        unique case (state_reg)
            n2cd_pkg::S_YEAR:  sub = n2cd_pkg::year_ns(year_reg);
            n2cd_pkg::S_MONTH: sub = n2cd_pkg::month_ns(year_reg, cnt_reg);
            n2cd_pkg::S_DAY:   sub = n2cd_pkg::NS_PER_DAY  << cnt_reg[2:0];
            n2cd_pkg::S_HOUR:  sub = n2cd_pkg::NS_PER_HOUR << cnt_reg[2:0];
            n2cd_pkg::S_MIN:   sub = n2cd_pkg::NS_PER_MIN  << cnt_reg[2:0];
            n2cd_pkg::S_SEC:   sub = n2cd_pkg::NS_PER_SEC  << cnt_reg[2:0];
            default:           sub = '0;
        endcase
    end

    n2cd_step_unit u_step
    (
        .rem (rem_reg),
        .sub (sub),
        .res (step)
    );

    // Sequencer next state
    always_comb
    begin
        state_next  = state_reg;
        rem_next    = rem_reg;
        year_next   = year_reg;
        month_next  = month_reg;
        dd_next     = dd_reg;
        hh_next     = hh_reg;
        mm_next     = mm_reg;
        ss_next     = ss_reg;
        cnt_next    = cnt_reg;
        load_out    = 1'b0;

        unique case (state_reg)
            n2cd_pkg::S_IDLE:
            begin
                if (in_ch.valid)
                begin
                    rem_next   = in_ch.raw_nanoseconds;
                    year_next  = n2cd_pkg::BASE_YEAR;
                    month_next = 4'd1;
                    state_next = n2cd_pkg::S_YEAR;
                end
            end
            n2cd_pkg::S_YEAR:
            begin
                if (step.ge && (year_reg != n2cd_pkg::YEAR_LIMIT))
                begin
                    rem_next  = step.diff;
                    year_next = year_reg + 12'd1;
                end
                else
                begin
                    cnt_next   = 4'd0;
                    state_next = n2cd_pkg::S_MONTH;
                end
            end
            n2cd_pkg::S_MONTH:
            begin
                if (step.ge)
                begin
                    rem_next   = step.diff;
                    month_next = month_reg + 4'd1;
                end
                if (!step.ge || (cnt_reg == n2cd_pkg::LAST_MONTH_IDX))
                begin
                    cnt_next   = 4'd4;
                    dd_next    = '0;
                    state_next = n2cd_pkg::S_DAY;
                end
                else
                begin
                    cnt_next = cnt_reg + 4'd1;
                end
            end
            n2cd_pkg::S_DAY:
            begin
                if (step.ge)
                begin
                    rem_next = step.diff;
                end
                dd_next = {dd_reg[3:0], step.ge};
                if (cnt_reg == 4'd0)
                begin
                    cnt_next   = 4'd4;
                    hh_next    = '0;
                    state_next = n2cd_pkg::S_HOUR;
                end
                else
                begin
                    cnt_next = cnt_reg - 4'd1;
                end
            end
            n2cd_pkg::S_HOUR:
            begin
                if (step.ge)
                begin
                    rem_next = step.diff;
                end
                hh_next = {hh_reg[3:0], step.ge};
                if (cnt_reg == 4'd0)
                begin
                    cnt_next   = 4'd5;
                    mm_next    = '0;
                    state_next = n2cd_pkg::S_MIN;
                end
                else
                begin
                    cnt_next = cnt_reg - 4'd1;
                end
            end
            n2cd_pkg::S_MIN:
            begin
                if (step.ge)
                begin
                    rem_next = step.diff;
                end
                mm_next = {mm_reg[4:0], step.ge};
                if (cnt_reg == 4'd0)
                begin
                    cnt_next   = 4'd5;
                    ss_next    = '0;
                    state_next = n2cd_pkg::S_SEC;
                end
                else
                begin
                    cnt_next = cnt_reg - 4'd1;
                end
            end
            n2cd_pkg::S_SEC:
            begin
                if (step.ge)
                begin
                    rem_next = step.diff;
                end
                ss_next = {ss_reg[4:0], step.ge};
                if (cnt_reg == 4'd0)
                begin
                    state_next = n2cd_pkg::S_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg - 4'd1;
                end
            end
            n2cd_pkg::S_DONE:
            begin
                // hand off once the output register is free or being drained
                if (!ovalid_reg || out_ch.ready)
                begin
                    load_out   = 1'b1;
                    state_next = n2cd_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = n2cd_pkg::S_IDLE;
            end
        endcase
    end

    // Output valid tracking
    always_comb
    begin
        ovalid_next = ovalid_reg;
        if (out_ch.ready)
        begin
            ovalid_next = 1'b0;
        end
        if (load_out)
        begin
            ovalid_next = 1'b1;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= n2cd_pkg::S_IDLE;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        rem_reg   <= rem_next;
        year_reg  <= year_next;
        month_reg <= month_next;
        dd_reg    <= dd_next;
        hh_reg    <= hh_next;
        mm_reg    <= mm_next;
        ss_reg    <= ss_next;
        cnt_reg   <= cnt_next;
    end

    // Output word register
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            oyear_reg  <= year_reg;
            omonth_reg <= month_reg;
            oday_reg   <= dd_reg + 5'd1;
            ohour_reg  <= hh_reg;
            omin_reg   <= mm_reg;
            osec_reg   <= ss_reg;
            ons_reg    <= rem_reg[29:0];
        end
    end

    assign in_ch.ready       = (state_reg == n2cd_pkg::S_IDLE);
    assign out_ch.valid      = ovalid_reg;
    assign out_ch.year       = oyear_reg;
    assign out_ch.month      = omonth_reg;
    assign out_ch.day        = oday_reg;
    assign out_ch.hour       = ohour_reg;
    assign out_ch.minute     = omin_reg;
    assign out_ch.second     = osec_reg;
    assign out_ch.nanosecond = ons_reg;

endmodule

[tb/testbench.sv]
// Self-checking testbench for nanoseconds_to_calendar_date: drives nanosecond counts
// and compares every calendar word with a predicted date computed in the bench.
// Depends on n2cd_pkg, n2cd_if and the RTL of nanoseconds_to_calendar_date.
`timescale 1ns / 1ps

module testbench;

    localparam int unsigned FIRST_YEAR    = 2000;
    localparam int unsigned LAST_YEAR     = 2584;
    localparam int unsigned YEAR_CAP      = 4000;
    localparam int unsigned RESET_CYCLES  = 7;
    localparam int unsigned PHASE_WORDS   = 228;
    localparam int unsigned DRAIN_CYCLES  = 700;
    localparam int unsigned CYCLE_LIMIT   = 3000000;
    localparam int unsigned PRINT_LIMIT   = 100;

    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [29:0] nanosecond;
    } cal_date_t;

    typedef struct {
        logic [63:0] count;
        cal_date_t   date;
    } pending_date_t;

    // Date predictor plus the queue of dates still owed by the block
    class calendar_scoreboard;
        pending_date_t pending_dates[$];
        int unsigned   mismatches;

        function new();
            mismatches = 0;
        endfunction

        static function logic has_leap_second(int unsigned yr);
            return (yr == 2005) || (yr == 2008) || (yr == 2015) || (yr == 2016);
        endfunction

        // Leap every fourth year counted from 2000, no century rule
        static function logic [63:0] year_length_ns(int unsigned yr);
            logic [63:0] len;
            len = (((yr - FIRST_YEAR) % 4) == 0) ? 64'd366 * n2cd_pkg::NS_PER_DAY
                                                 : 64'd365 * n2cd_pkg::NS_PER_DAY;
            if (has_leap_second(yr))
            begin
                len = len + n2cd_pkg::NS_PER_SEC;
            end
            return len;
        endfunction

        // Month k counts from 0 = January; June of 2012 and 2015 is one second longer
        static function logic [63:0] month_length_ns(int unsigned yr, int k);
            logic [63:0] days;
            logic [63:0] len;
            case (k)
                1:           days = (((yr - FIRST_YEAR) % 4) == 0) ? 64'd29 : 64'd28;
                3, 5, 8, 10: days = 64'd30;
                default:     days = 64'd31;
            endcase
            len = days * n2cd_pkg::NS_PER_DAY;
            if (((yr == 2012) || (yr == 2015)) && (k == 5))
            begin
                len = len + n2cd_pkg::NS_PER_SEC;
            end
            return len;
        endfunction

        static function cal_date_t to_calendar(logic [63:0] count);
            cal_date_t   d;
            logic [63:0] rest;
            logic [63:0] len;
            logic [63:0] q;
            int unsigned yr;
            int unsigned mon;
            rest = count;
            yr   = FIRST_YEAR;
            // strip whole years
            while (yr < YEAR_CAP)
            begin
                len = year_length_ns(yr);
                if (rest < len)
                begin
                    break;
                end
                rest = rest - len;
                yr++;
            end
            // strip whole months; a thirteenth month is possible
            mon = 1;
            for (int k = 0; k < 12; k++)
            begin
                len = month_length_ns(yr, k);
                if (rest < len)
                begin
                    break;
                end
                rest = rest - len;
                mon++;
            end
            d.year  = 12'(yr);
            d.month = 4'(mon);
            q = rest / n2cd_pkg::NS_PER_DAY;
            rest = rest - q * n2cd_pkg::NS_PER_DAY;
            d.day = 5'(q + 64'd1);
            q = rest / n2cd_pkg::NS_PER_HOUR;
            rest = rest - q * n2cd_pkg::NS_PER_HOUR;
            d.hour = 5'(q);
            q = rest / n2cd_pkg::NS_PER_MIN;
            rest = rest - q * n2cd_pkg::NS_PER_MIN;
            d.minute = 6'(q);
            q = rest / n2cd_pkg::NS_PER_SEC;
            rest = rest - q * n2cd_pkg::NS_PER_SEC;
            d.second = 6'(q);
            d.nanosecond = 30'(rest);
            return d;
        endfunction

        function void note_count(logic [63:0] count);
            pending_date_t p;
            p.count = count;
            p.date  = to_calendar(count);
            pending_dates.push_back(p);
        endfunction

        task report(string msg);
            if (mismatches < PRINT_LIMIT)
            begin
                $display("%0t ns: MISMATCH %s", $time, msg);
            end
            mismatches++;
        endtask

        task compare_field(string name, logic [63:0] count, logic [63:0] want,
                           logic [63:0] got);
            if (want !== got)
            begin
                report($sformatf("count %0d: %s expected %0d got %0d", count, name,
                                 want, got));
            end
        endtask

        task check_date(cal_date_t got);
            pending_date_t p;
            if (pending_dates.size() == 0)
            begin
                report("calendar word with no count outstanding");
            end
            else
            begin
                p = pending_dates.pop_front();
                compare_field("year", p.count, p.date.year, got.year);
                compare_field("month", p.count, p.date.month, got.month);
                compare_field("day", p.count, p.date.day, got.day);
                compare_field("hour", p.count, p.date.hour, got.hour);
                compare_field("minute", p.count, p.date.minute, got.minute);
                compare_field("second", p.count, p.date.second, got.second);
                compare_field("nanosecond", p.count, p.date.nanosecond, got.nanosecond);
            end
        endtask

        task flush_leftovers();
            pending_date_t p;
            while (pending_dates.size() != 0)
            begin
                p = pending_dates.pop_front();
                report($sformatf("count %0d: calendar word never arrived", p.count));
            end
        endtask
    endclass

    logic clk;
    logic rst_n;

    n2cd_in_if  in_ch();
    n2cd_out_if out_ch();

    nanoseconds_to_calendar_date DUT
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    calendar_scoreboard sb = new();

    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    int unsigned cycle_count;
    logic [63:0] year_begin [FIRST_YEAR:LAST_YEAR];

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Watchdog
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // Receiver back-pressure, drawn fresh each cycle
    initial
    begin
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Monitor: record accepted counts, check accepted calendar words
    always @(posedge clk)
    begin
        cal_date_t got;
        if (in_ch.valid && in_ch.ready)
        begin
            sb.note_count(in_ch.raw_nanoseconds);
        end
        if (out_ch.valid && out_ch.ready)
        begin
            got.year       = out_ch.year;
            got.month      = out_ch.month;
            got.day        = out_ch.day;
            got.hour       = out_ch.hour;
            got.minute     = out_ch.minute;
            got.second     = out_ch.second;
            got.nanosecond = out_ch.nanosecond;
            sb.check_date(got);
        end
    end

    function automatic logic [63:0] month_begin(int unsigned yr, int k);
        logic [63:0] start;
        start = year_begin[yr];
        for (int j = 0; j < k; j++)
        begin
            start = start + calendar_scoreboard::month_length_ns(yr, j);
        end
        return start;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Random count: mostly near year and month edges, some anywhere in range
    function automatic logic [63:0] random_count();
        int unsigned pick;
        int unsigned yr;
        logic [63:0] base;
        pick = $urandom_range(99);
        yr = ($urandom_range(3) == 0) ? $urandom_range(2031, LAST_YEAR - 1)
                                      : $urandom_range(FIRST_YEAR, 2030);
        if (pick < 30)
        begin
            return rand64();
        end
        else if (pick < 85)
        begin
            base = (pick < 60) ? year_begin[yr + 1] : month_begin(yr, $urandom_range(1, 12));
            if ($urandom_range(3) == 0)
            begin
                return base - 64'd1 - 64'($urandom_range(3));
            end
            return base - 2 * n2cd_pkg::NS_PER_SEC + rand64() % (4 * n2cd_pkg::NS_PER_SEC);
        end
        yr = $urandom_range(FIRST_YEAR, LAST_YEAR - 1);
        return year_begin[yr] + rand64() % calendar_scoreboard::year_length_ns(yr);
    endfunction

    // Present one count word; called and returning at a falling edge
    task automatic send_count(input logic [63:0] count);
        int unsigned gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct)
        begin
            gap++;
        end
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.valid           <= 1'b1;
        in_ch.raw_nanoseconds <= count;
        do
        begin
            @(posedge clk);
        end
        while (!in_ch.ready);
        @(negedge clk);
    endtask

    int unsigned phase_send [4] = '{0, 84, 0, 19};
    int unsigned phase_recv [4] = '{0, 0, 84, 19};

    initial
    begin
        logic [63:0] directed [$];
        rst_n                 = 1'b0;
        in_ch.valid           = 1'b0;
        in_ch.raw_nanoseconds = '0;
        send_idle_pct         = 0;
        recv_stall_pct        = 0;

        year_begin[FIRST_YEAR] = '0;
        for (int unsigned y = FIRST_YEAR + 1; y <= LAST_YEAR; y++)
        begin
            year_begin[y] = year_begin[y - 1] + calendar_scoreboard::year_length_ns(y - 1);
        end

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: range ends, month thirteen, June extra second, 2012 shortfall
        directed = '{64'd0, 64'hFFFF_FFFF_FFFF_FFFF, n2cd_pkg::NS_PER_SEC - 64'd1,
                     year_begin[2001] - 64'd1, year_begin[2001],
                     year_begin[2006] - 64'd1, year_begin[2006] - n2cd_pkg::NS_PER_SEC,
                     year_begin[2009] - 64'd1, year_begin[2017] - 64'd1,
                     year_begin[2017] - n2cd_pkg::NS_PER_SEC - 64'd1,
                     month_begin(2012, 6) - 64'd1,
                     month_begin(2012, 6) - n2cd_pkg::NS_PER_SEC - 64'd1,
                     month_begin(2015, 6) - 64'd1, month_begin(2015, 6),
                     year_begin[2013] - 64'd1, year_begin[2013] - n2cd_pkg::NS_PER_SEC,
                     year_begin[2016] - 64'd1, month_begin(2004, 2) - 64'd1,
                     month_begin(2004, 1), month_begin(2100, 2) - 64'd1,
                     year_begin[LAST_YEAR] - 64'd1, year_begin[LAST_YEAR]};
        foreach (directed[i])
        begin
            send_count(directed[i]);
        end

        // Random words under each idling pattern
        for (int p = 0; p < 4; p++)
        begin
            send_idle_pct  = phase_send[p];
            recv_stall_pct = phase_recv[p];
            repeat (PHASE_WORDS) send_count(random_count());
        end
        in_ch.valid <= 1'b0;

        while (sb.pending_dates.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        sb.flush_leftovers();

        if (sb.mismatches == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

[files.f]
hdl/n2cd_pkg.sv
hdl/n2cd_if.sv
hdl/n2cd_step_unit.sv
hdl/nanoseconds_to_calendar_date.sv
tb/testbench.sv
